// File: src/bdvf_pkg.sv
`timescale 1ns / 1ps
// shared constants, types and register codes for the band distortion block
package bdvf_pkg;

    localparam int WINDOW_LEN = 4096;
    localparam int PTR_W = (WINDOW_LEN > 1) ? $clog2(WINDOW_LEN) : 1;

    localparam int SAMPLE_W = 24;
    localparam int E_W = 48;
    localparam int LINE_W = E_W + SAMPLE_W;
    localparam int SUM_W = 60;
    localparam int ROOT_W = 30;

    localparam int DIV_REM_W = 36;
    localparam int DIV_BITS_W = 64;
    localparam int DIV_Q_W = 48;
    localparam int DIV_CNT_W = 6;
    localparam int SQRT_CNT_W = 5;

    localparam logic [DIV_CNT_W-1:0] DIV_CNT_E = 6'd47;
    localparam logic [DIV_CNT_W-1:0] DIV_CNT_SC = 6'd20;
    localparam logic [DIV_CNT_W-1:0] DIV_CNT_TERM = 6'd31;
    localparam logic [SQRT_CNT_W-1:0] SQRT_STEPS = 5'd30;

    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;

    localparam int ADDR_W = 5;
    localparam logic [2:0] REG_BAND_GAIN = 3'd0;
    localparam logic [2:0] REG_CLIP_LEVEL = 3'd1;
    localparam logic [2:0] REG_ENERGY_COMPRESS = 3'd2;
    localparam logic [2:0] REG_FOLLOW_AMOUNT = 3'd3;
    localparam logic [2:0] REG_MIX_WEIGHT = 3'd4;

    localparam logic [23:0] RST_BAND_GAIN = 24'd65536;
    localparam logic [16:0] RST_CLIP_LEVEL = 17'd65536;
    localparam logic [23:0] RST_ENERGY_COMPRESS = 24'd0;
    localparam logic [16:0] RST_FOLLOW_AMOUNT = 17'd0;
    localparam logic [23:0] RST_MIX_WEIGHT = 24'd65536;

    localparam logic [20:0] ONE_Q20 = 21'h100000;

    typedef struct packed {
        logic        neg;
        logic [23:0] mag;
    } item_t;

    typedef struct packed {
        logic  valid;
        item_t item;
    } q_head_t;

    typedef struct packed {
        logic [23:0]        band_gain;
        logic [16:0]        clip_level;
        logic [23:0]        energy_compress;
        logic [16:0]        follow_amount;
        logic signed [23:0] mix_weight;
    } cfg_t;

    typedef struct packed {
        logic                  start;
        logic [DIV_REM_W-1:0]  rem_init;
        logic [DIV_BITS_W-1:0] bits;
        logic [DIV_CNT_W-1:0]  count;
        logic [DIV_REM_W-1:0]  den;
    } div_req_t;

    typedef struct packed {
        logic               busy;
        logic [DIV_Q_W-1:0] quot;
    } div_rsp_t;

    typedef struct packed {
        logic             start;
        logic [SUM_W-1:0] value;
    } sqrt_req_t;

    typedef struct packed {
        logic              busy;
        logic [ROOT_W-1:0] root;
    } sqrt_rsp_t;

endpackage

// File: src/band_distortion_volume_follow.sv
`timescale 1ns / 1ps
// the back end works on one item at a time and waits while the output register is full
// per item the shared radix-2 divider runs three divisions (47, 20 and 31 quotient bits,
//   the 20-bit one overlapping a 30-bit root), and a second 30-bit root follows
// the input queue holds four requests; one finished result waits in the output register
// after reset a clearing pass zeroes all 4096 window lines; full stays high meanwhile
// registers and window sums reset to their defaults, asynchronous active-low reset
module band_distortion_volume_follow (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          push,
    output logic                          full,
    input  logic signed [23:0]            band_sample,
    output logic                          empty,
    input  logic                          pop,
    output logic signed [23:0]            shaped_sample,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [bdvf_pkg::ADDR_W-1:0]   paddr,
    input  logic [31:0]                   pwdata,
    output logic [31:0]                   prdata,
    output logic                          pready
);

    bdvf_pkg::cfg_t       cfg_reg, cfg_next;
    bdvf_pkg::q_head_t    head;
    bdvf_pkg::div_req_t   div_req;
    bdvf_pkg::div_rsp_t   div_rsp;
    bdvf_pkg::sqrt_req_t  sqrt_req;
    bdvf_pkg::sqrt_rsp_t  sqrt_rsp;
    logic                 pop_item;
    logic                 clearing;
    logic                 ram_we;
    logic [bdvf_pkg::PTR_W-1:0]  ram_waddr;
    logic [bdvf_pkg::PTR_W-1:0]  ram_raddr;
    logic [bdvf_pkg::LINE_W-1:0] ram_wdata;
    logic [bdvf_pkg::LINE_W-1:0] ram_rdata;
    logic                 res_valid;
    logic [23:0]          res_data;
    logic                 wr_en;

    assign pready = 1'b1;
    assign wr_en = psel && penable && pwrite && pready;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            case (paddr[4:2])
                bdvf_pkg::REG_BAND_GAIN:       cfg_next.band_gain = pwdata[23:0];
                bdvf_pkg::REG_CLIP_LEVEL:      cfg_next.clip_level = pwdata[16:0];
                bdvf_pkg::REG_ENERGY_COMPRESS: cfg_next.energy_compress = pwdata[23:0];
                bdvf_pkg::REG_FOLLOW_AMOUNT:   cfg_next.follow_amount = pwdata[16:0];
                bdvf_pkg::REG_MIX_WEIGHT:      cfg_next.mix_weight = pwdata[23:0];
                default:                       cfg_next = cfg_reg;
            endcase
        end
    end

    always_comb
    begin
        case (paddr[4:2])
            bdvf_pkg::REG_BAND_GAIN:       prdata = {8'd0, cfg_reg.band_gain};
            bdvf_pkg::REG_CLIP_LEVEL:      prdata = {15'd0, cfg_reg.clip_level};
            bdvf_pkg::REG_ENERGY_COMPRESS: prdata = {8'd0, cfg_reg.energy_compress};
            bdvf_pkg::REG_FOLLOW_AMOUNT:   prdata = {15'd0, cfg_reg.follow_amount};
            bdvf_pkg::REG_MIX_WEIGHT:
                prdata = {{8{cfg_reg.mix_weight[23]}}, cfg_reg.mix_weight};
            default:                       prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.band_gain <= bdvf_pkg::RST_BAND_GAIN;
            cfg_reg.clip_level <= bdvf_pkg::RST_CLIP_LEVEL;
            cfg_reg.energy_compress <= bdvf_pkg::RST_ENERGY_COMPRESS;
            cfg_reg.follow_amount <= bdvf_pkg::RST_FOLLOW_AMOUNT;
            cfg_reg.mix_weight <= bdvf_pkg::RST_MIX_WEIGHT;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    bdvf_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .push        (push),
        .band_sample (band_sample),
        .block       (clearing),
        .full        (full),
        .head        (head),
        .pop         (pop_item)
    );

    bdvf_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    bdvf_sqrt u_sqrt (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (sqrt_req),
        .rsp   (sqrt_rsp)
    );

    // one line holds the pre energy and the clipped sample of each window slot
    bdvf_ram #(
        .WIDTH (bdvf_pkg::LINE_W),
        .DEPTH (bdvf_pkg::WINDOW_LEN)
    ) u_line (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    bdvf_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .head      (head),
        .pop_item  (pop_item),
        .div_req   (div_req),
        .div_rsp   (div_rsp),
        .sqrt_req  (sqrt_req),
        .sqrt_rsp  (sqrt_rsp),
        .ram_we    (ram_we),
        .ram_waddr (ram_waddr),
        .ram_wdata (ram_wdata),
        .ram_raddr (ram_raddr),
        .ram_rdata (ram_rdata),
        .res_valid (res_valid),
        .res_data  (res_data),
        .res_pop   (pop && res_valid),
        .clearing  (clearing)
    );

    assign empty = !res_valid;
    assign shaped_sample = res_data;

    a_div_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
        div_req.start |-> !div_rsp.busy)
        else $error("divider started while busy");

    a_sqrt_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
        sqrt_req.start |-> !sqrt_rsp.busy)
        else $error("root unit started while busy");

    a_clear_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
        clearing |-> (full && !pop_item))
        else $error("request taken during clearing pass");

endmodule

// File: src/bdvf_ram.sv
`timescale 1ns / 1ps
// generic single-write, single-read ram with registered read data
module bdvf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// File: src/bdvf_front.sv
`timescale 1ns / 1ps
// front end: takes requests, splits sign and magnitude, holds them in a short queue
module bdvf_front (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   push,
    input  logic [23:0]            band_sample,
    input  logic                   block,
    output logic                   full,
    output bdvf_pkg::q_head_t      head,
    input  logic                   pop
);

    bdvf_pkg::item_t fifo_reg [bdvf_pkg::QUEUE_DEPTH];
    logic [bdvf_pkg::QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [bdvf_pkg::QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [bdvf_pkg::QPTR_W:0]   count_reg, count_next;
    bdvf_pkg::item_t             item_in;
    logic                        do_push;
    logic                        do_pop;

    always_comb
    begin
        item_in.neg = band_sample[23];
        // two's complement negate also gives 2^23 for the most negative code
        item_in.mag = band_sample[23] ? (~band_sample + 24'd1) : band_sample;
    end

    assign full = block || (count_reg == (bdvf_pkg::QPTR_W+1)'(bdvf_pkg::QUEUE_DEPTH));
    assign do_push = push && !full;
    assign do_pop = pop && (count_reg != '0);

    assign head.valid = (count_reg != '0);
    assign head.item = fifo_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = do_push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = do_pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next = count_reg;
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            fifo_reg[wr_ptr_reg] <= item_in;
        end
    end

endmodule

// File: src/bdvf_div.sv
`timescale 1ns / 1ps
// radix-2 restoring divider, one quotient bit per cycle
module bdvf_div (
    input  logic                clk,
    input  logic                rst_n,
    input  bdvf_pkg::div_req_t  req,
    output bdvf_pkg::div_rsp_t  rsp
);

    logic [bdvf_pkg::DIV_REM_W-1:0]  rem_reg, rem_next;
    logic [bdvf_pkg::DIV_REM_W-1:0]  den_reg, den_next;
    logic [bdvf_pkg::DIV_BITS_W-1:0] bits_reg, bits_next;
    logic [bdvf_pkg::DIV_Q_W-1:0]    quot_reg, quot_next;
    logic [bdvf_pkg::DIV_CNT_W-1:0]  cnt_reg, cnt_next;
    logic                            busy_reg, busy_next;
    logic [bdvf_pkg::DIV_REM_W:0]    trial;

    always_comb
    begin
        trial = {rem_reg, bits_reg[bdvf_pkg::DIV_BITS_W-1]};
        rem_next = rem_reg;
        den_next = den_reg;
        bits_next = bits_reg;
        quot_next = quot_reg;
        cnt_next = cnt_reg;
        busy_next = busy_reg;
        if (req.start)
        begin
            rem_next = req.rem_init;
            den_next = req.den;
            bits_next = req.bits;
            quot_next = '0;
            cnt_next = req.count;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            // remainder stays below the divisor, so trial fits one extra bit
            if (trial >= {1'b0, den_reg})
            begin
                rem_next = bdvf_pkg::DIV_REM_W'(trial - {1'b0, den_reg});
                quot_next = {quot_reg[bdvf_pkg::DIV_Q_W-2:0], 1'b1};
            end
            else
            begin
                rem_next = trial[bdvf_pkg::DIV_REM_W-1:0];
                quot_next = {quot_reg[bdvf_pkg::DIV_Q_W-2:0], 1'b0};
            end
            bits_next = {bits_reg[bdvf_pkg::DIV_BITS_W-2:0], 1'b0};
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == bdvf_pkg::DIV_CNT_W'(1))
            begin
                busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        den_reg <= den_next;
        bits_reg <= bits_next;
        quot_reg <= quot_next;
    end

    assign rsp.busy = busy_reg;
    assign rsp.quot = quot_reg;

endmodule

// File: src/bdvf_sqrt.sv
`timescale 1ns / 1ps
// digit-by-digit floor square root, one result bit per cycle
module bdvf_sqrt (
    input  logic                 clk,
    input  logic                 rst_n,
    input  bdvf_pkg::sqrt_req_t  req,
    output bdvf_pkg::sqrt_rsp_t  rsp
);

    logic [bdvf_pkg::SUM_W-1:0]      val_reg, val_next;
    logic [32:0]                     rem_reg, rem_next;
    logic [bdvf_pkg::ROOT_W-1:0]     root_reg, root_next;
    logic [bdvf_pkg::SQRT_CNT_W-1:0] cnt_reg, cnt_next;
    logic                            busy_reg, busy_next;
    logic [32:0]                     shifted;
    logic [32:0]                     test;

    always_comb
    begin
        shifted = {rem_reg[30:0], val_reg[bdvf_pkg::SUM_W-1 -: 2]};
        test = {1'b0, root_reg, 2'b01};
        val_next = val_reg;
        rem_next = rem_reg;
        root_next = root_reg;
        cnt_next = cnt_reg;
        busy_next = busy_reg;
        if (req.start)
        begin
            val_next = req.value;
            rem_next = '0;
            root_next = '0;
            cnt_next = bdvf_pkg::SQRT_STEPS;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (shifted >= test)
            begin
                rem_next = shifted - test;
                root_next = {root_reg[bdvf_pkg::ROOT_W-2:0], 1'b1};
            end
            else
            begin
                rem_next = shifted;
                root_next = {root_reg[bdvf_pkg::ROOT_W-2:0], 1'b0};
            end
            val_next = {val_reg[bdvf_pkg::SUM_W-3:0], 2'b00};
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == bdvf_pkg::SQRT_CNT_W'(1))
            begin
                busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        val_reg <= val_next;
        rem_reg <= rem_next;
        root_reg <= root_next;
    end

    assign rsp.busy = busy_reg;
    assign rsp.root = root_reg;

endmodule

// File: src/bdvf_back.sv
`timescale 1ns / 1ps
// back end: sequencer that runs the energy windows, clipping and volume follow
module bdvf_back (
    input  logic                               clk,
    input  logic                               rst_n,
    input  bdvf_pkg::cfg_t                     cfg,
    input  bdvf_pkg::q_head_t                  head,
    output logic                               pop_item,
    output bdvf_pkg::div_req_t                 div_req,
    input  bdvf_pkg::div_rsp_t                 div_rsp,
    output bdvf_pkg::sqrt_req_t                sqrt_req,
    input  bdvf_pkg::sqrt_rsp_t                sqrt_rsp,
    output logic                               ram_we,
    output logic [bdvf_pkg::PTR_W-1:0]         ram_waddr,
    output logic [bdvf_pkg::LINE_W-1:0]        ram_wdata,
    output logic [bdvf_pkg::PTR_W-1:0]         ram_raddr,
    input  logic [bdvf_pkg::LINE_W-1:0]        ram_rdata,
    output logic                               res_valid,
    output logic [23:0]                        res_data,
    input  logic                               res_pop,
    output logic                               clearing
);

    typedef enum logic [22:0] {
        ST_CLEAR = 23'd1 << 0,
        ST_IDLE  = 23'd1 << 1,
        ST_X2    = 23'd1 << 2,
        ST_CHI   = 23'd1 << 3,
        ST_CLO   = 23'd1 << 4,
        ST_DEN   = 23'd1 << 5,
        ST_EGO   = 23'd1 << 6,
        ST_EWAIT = 23'd1 << 7,
        ST_PSUM  = 23'd1 << 8,
        ST_SGO   = 23'd1 << 9,
        ST_SWAIT = 23'd1 << 10,
        ST_YY    = 23'd1 << 11,
        ST_OLD   = 23'd1 << 12,
        ST_QSUM  = 23'd1 << 13,
        ST_QGO   = 23'd1 << 14,
        ST_QWAIT = 23'd1 << 15,
        ST_FMUL  = 23'd1 << 16,
        ST_TGO   = 23'd1 << 17,
        ST_TWAIT = 23'd1 << 18,
        ST_SCALE = 23'd1 << 19,
        ST_ZMUL  = 23'd1 << 20,
        ST_WMUL  = 23'd1 << 21,
        ST_OUT   = 23'd1 << 22
    } state_t;

    state_t                          state_reg, state_next;
    logic [bdvf_pkg::PTR_W-1:0]      ptr_reg, ptr_next;
    logic [bdvf_pkg::PTR_W-1:0]      ptr_inc;
    logic [bdvf_pkg::SUM_W-1:0]      pre_sum_reg, pre_sum_next;
    logic [bdvf_pkg::SUM_W-1:0]      post_sum_reg, post_sum_next;
    logic                            res_valid_reg, res_valid_next;
    logic [23:0]                     res_data_reg;

    logic                            neg_reg;
    logic [23:0]                     mag_reg;
    logic [46:0]                     x2_reg;
    logic [50:0]                     acc_reg;
    logic [35:0]                     den_reg;
    logic [31:0]                     m_reg;
    logic [47:0]                     e_reg;
    logic [bdvf_pkg::ROOT_W-1:0]     rp_reg;
    logic [bdvf_pkg::ROOT_W-1:0]     rpost_reg;
    logic [20:0]                     ymag_reg;
    logic [40:0]                     y2_reg;
    logic                            scale_neg_reg;
    logic [31:0]                     scale_mag_reg;
    logic [63:0]                     prod_reg;

    logic [31:0]                     mul_a;
    logic [31:0]                     mul_b;
    logic [63:0]                     product;
    logic [47:0]                     old_e;
    logic [23:0]                     old_y;
    logic [23:0]                     old_mag;
    logic [23:0]                     y_signed;
    logic [20:0]                     lim;
    logic [23:0]                     mix_mag;
    logic [50:0]                     fterm;
    logic [33:0]                     scale_s;
    logic [39:0]                     w_mag;
    logic                            w_neg;
    logic [23:0]                     w_sat;
    logic                            out_free;
    logic [51:0]                     cx_sum;

    assign ptr_inc = (ptr_reg == bdvf_pkg::PTR_W'(bdvf_pkg::WINDOW_LEN - 1)) ?
                     '0 : ptr_reg + 1'b1;

    assign old_e = ram_rdata[bdvf_pkg::LINE_W-1:bdvf_pkg::SAMPLE_W];
    assign old_y = ram_rdata[bdvf_pkg::SAMPLE_W-1:0];
    assign old_mag = old_y[23] ? (~old_y + 24'd1) : old_y;
    assign y_signed = neg_reg ? (~{3'b000, ymag_reg} + 24'd1) : {3'b000, ymag_reg};
    assign lim = {cfg.clip_level, 4'b0000};
    assign mix_mag = cfg.mix_weight[23] ? (~cfg.mix_weight + 24'd1) : cfg.mix_weight;
    assign fterm = {prod_reg[46:0], 4'b0000};
    assign cx_sum = {1'b0, acc_reg} + {28'd0, prod_reg[43:20]};

    // the window line is read at the entry that drops out next, written at the current one
    assign ram_raddr = ptr_inc;
    assign ram_waddr = ptr_reg;
    assign ram_we = (state_reg == ST_CLEAR) || (state_reg == ST_YY);
    assign ram_wdata = (state_reg == ST_CLEAR) ? '0 : {e_reg, y_signed};

    assign pop_item = (state_reg == ST_IDLE) && head.valid;
    assign clearing = (state_reg == ST_CLEAR);
    assign out_free = !res_valid_reg || res_pop;

    // shared multiplier, operands chosen by state
    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        case (state_reg)
            ST_X2:
            begin
                mul_a = {8'd0, mag_reg};
                mul_b = {8'd0, mag_reg};
            end
            ST_CHI:
            begin
                mul_a = {5'd0, prod_reg[46:20]};
                mul_b = {8'd0, cfg.energy_compress};
            end
            ST_CLO:
            begin
                mul_a = {12'd0, x2_reg[19:0]};
                mul_b = {8'd0, cfg.energy_compress};
            end
            ST_DEN:
            begin
                mul_a = {8'd0, mag_reg};
                mul_b = {8'd0, cfg.band_gain};
            end
            ST_YY:
            begin
                mul_a = {11'd0, ymag_reg};
                mul_b = {11'd0, ymag_reg};
            end
            ST_OLD:
            begin
                mul_a = {8'd0, old_mag};
                mul_b = {8'd0, old_mag};
            end
            ST_FMUL:
            begin
                mul_a = {15'd0, cfg.follow_amount};
                mul_b = {2'd0, rp_reg};
            end
            ST_ZMUL:
            begin
                mul_a = {11'd0, ymag_reg};
                mul_b = scale_mag_reg;
            end
            ST_WMUL:
            begin
                mul_a = prod_reg[51:20];
                mul_b = {8'd0, mix_mag};
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign product = {32'd0, mul_a} * {32'd0, mul_b};

    // requests to the shared divider and root units
    always_comb
    begin
        div_req = '0;
        sqrt_req = '0;
        case (state_reg)
            ST_EGO:
            begin
                div_req.start = 1'b1;
                div_req.rem_init = {16'd0, x2_reg[46:27]};
                div_req.bits = {x2_reg[26:0], 37'd0};
                div_req.count = bdvf_pkg::DIV_CNT_E;
                div_req.den = den_reg;
            end
            ST_SGO:
            begin
                div_req.start = 1'b1;
                div_req.rem_init = {4'd0, m_reg};
                div_req.bits = '0;
                div_req.count = bdvf_pkg::DIV_CNT_SC;
                div_req.den = {15'd0, bdvf_pkg::ONE_Q20} + {4'd0, m_reg};
                sqrt_req.start = 1'b1;
                sqrt_req.value = pre_sum_reg;
            end
            ST_QGO:
            begin
                sqrt_req.start = 1'b1;
                sqrt_req.value = post_sum_reg;
            end
            ST_TGO:
            begin
                div_req.start = 1'b1;
                div_req.rem_init = {16'd0, fterm[50:31]};
                div_req.bits = {fterm[30:0], 33'd0};
                div_req.count = bdvf_pkg::DIV_CNT_TERM;
                div_req.den = {6'd0, rpost_reg};
            end
            default:
            begin
                div_req = '0;
                sqrt_req = '0;
            end
        endcase
    end

    // sign-magnitude result and saturation, and the signed follow scale
    always_comb
    begin
        w_mag = prod_reg[55:16];
        w_neg = neg_reg ^ scale_neg_reg ^ cfg.mix_weight[23];
        if (w_neg)
        begin
            w_sat = (w_mag > 40'h800000) ? 24'h800000 : (~w_mag[23:0] + 24'd1);
        end
        else
        begin
            w_sat = (w_mag > 40'h7FFFFF) ? 24'h7FFFFF : w_mag[23:0];
        end
        scale_s = {2'b00, div_rsp.quot[31:0]} + {13'd0, bdvf_pkg::ONE_Q20}
                  - {13'd0, cfg.follow_amount, 4'b0000};
    end

    always_comb
    begin
        state_next = state_reg;
        ptr_next = ptr_reg;
        pre_sum_next = pre_sum_reg;
        post_sum_next = post_sum_reg;
        res_valid_next = res_valid_reg;
        if (res_pop)
        begin
            res_valid_next = 1'b0;
        end
        case (state_reg)
            ST_CLEAR:
            begin
                ptr_next = ptr_inc;
                if (ptr_reg == bdvf_pkg::PTR_W'(bdvf_pkg::WINDOW_LEN - 1))
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (head.valid)
                begin
                    state_next = ST_X2;
                end
            end
            ST_X2:    state_next = ST_CHI;
            ST_CHI:   state_next = ST_CLO;
            ST_CLO:   state_next = ST_DEN;
            ST_DEN:   state_next = ST_EGO;
            ST_EGO:   state_next = ST_EWAIT;
            ST_EWAIT:
            begin
                if (!div_rsp.busy)
                begin
                    state_next = ST_PSUM;
                end
            end
            ST_PSUM:
            begin
                pre_sum_next = pre_sum_reg + {12'd0, e_reg} - {12'd0, old_e};
                state_next = ST_SGO;
            end
            ST_SGO:   state_next = ST_SWAIT;
            ST_SWAIT:
            begin
                if (!div_rsp.busy && !sqrt_rsp.busy)
                begin
                    state_next = ST_YY;
                end
            end
            ST_YY:    state_next = ST_OLD;
            ST_OLD:   state_next = ST_QSUM;
            ST_QSUM:
            begin
                post_sum_next = post_sum_reg + {19'd0, y2_reg} - {12'd0, prod_reg[47:0]};
                state_next = ST_QGO;
            end
            ST_QGO:   state_next = ST_QWAIT;
            ST_QWAIT:
            begin
                if (!sqrt_rsp.busy)
                begin
                    state_next = ST_FMUL;
                end
            end
            ST_FMUL:  state_next = ST_TGO;
            ST_TGO:   state_next = ST_TWAIT;
            ST_TWAIT:
            begin
                if (!div_rsp.busy)
                begin
                    state_next = ST_SCALE;
                end
            end
            ST_SCALE: state_next = ST_ZMUL;
            ST_ZMUL:  state_next = ST_WMUL;
            ST_WMUL:  state_next = ST_OUT;
            ST_OUT:
            begin
                if (out_free)
                begin
                    res_valid_next = 1'b1;
                    ptr_next = ptr_inc;
                    state_next = ST_IDLE;
                end
            end
            default:  state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
            ptr_reg <= '0;
            pre_sum_reg <= '0;
            post_sum_reg <= '0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            ptr_reg <= ptr_next;
            pre_sum_reg <= pre_sum_next;
            post_sum_reg <= post_sum_next;
            res_valid_reg <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        case (state_reg)
            ST_IDLE:
            begin
                neg_reg <= head.item.neg;
                mag_reg <= head.item.mag;
            end
            ST_X2:
            begin
                prod_reg <= product;
            end
            ST_CHI:
            begin
                x2_reg <= prod_reg[46:0];
                prod_reg <= product;
            end
            ST_CLO:
            begin
                acc_reg <= prod_reg[50:0];
                prod_reg <= product;
            end
            ST_DEN:
            begin
                // 1.0 plus c*x^2 floored to q20
                den_reg <= {15'd0, bdvf_pkg::ONE_Q20} + cx_sum[51:16];
                prod_reg <= product;
            end
            ST_EGO:
            begin
                m_reg <= prod_reg[47:16];
            end
            ST_EWAIT:
            begin
                e_reg <= div_rsp.quot;
            end
            ST_SWAIT:
            begin
                rp_reg <= sqrt_rsp.root;
                ymag_reg <= (div_rsp.quot[20:0] > lim) ? lim : div_rsp.quot[20:0];
            end
            ST_YY:
            begin
                prod_reg <= product;
            end
            ST_OLD:
            begin
                y2_reg <= prod_reg[40:0];
                prod_reg <= product;
            end
            ST_QWAIT:
            begin
                // post root floored at 1.0
                rpost_reg <= (sqrt_rsp.root < {9'd0, bdvf_pkg::ONE_Q20}) ?
                             {9'd0, bdvf_pkg::ONE_Q20} : sqrt_rsp.root;
            end
            ST_FMUL:
            begin
                prod_reg <= product;
            end
            ST_SCALE:
            begin
                scale_neg_reg <= scale_s[33];
                scale_mag_reg <= scale_s[33] ? (~scale_s[31:0] + 32'd1) : scale_s[31:0];
            end
            ST_ZMUL:
            begin
                prod_reg <= product;
            end
            ST_WMUL:
            begin
                prod_reg <= product;
            end
            ST_OUT:
            begin
                if (out_free)
                begin
                    res_data_reg <= w_sat;
                end
            end
            default:
            begin
            end
        endcase
    end

    assign res_valid = res_valid_reg;
    assign res_data = res_data_reg;

endmodule

// File: tb/sv/tb_band_distortion_volume_follow.sv
`timescale 1ns / 1ps
// self-checking testbench for the band distortion volume follow block
module tb_band_distortion_volume_follow;

    localparam int CYCLE_LIMIT = 2000000;
    localparam int DRAIN_WAIT = 200;
    localparam int RANDOM_PHASES = 7;
    localparam int PHASE_ITEMS = 200;
    localparam logic [2:0] REG_UNUSED = 3'd7;
    localparam longint unsigned SUM_MASK = 64'h0FFF_FFFF_FFFF_FFFF;
    localparam longint unsigned Q20_ONE = 64'd1048576;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic push = 1'b0;
    logic full;
    logic signed [23:0] band_sample = '0;
    logic empty;
    logic pop = 1'b0;
    logic signed [23:0] shaped_sample;
    logic psel = 1'b0;
    logic penable = 1'b0;
    logic pwrite = 1'b0;
    logic [bdvf_pkg::ADDR_W-1:0] paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic pready;

    band_distortion_volume_follow u_dut (
        .clk(clk), .rst_n(rst_n), .push(push), .full(full), .band_sample(band_sample),
        .empty(empty), .pop(pop), .shaped_sample(shaped_sample),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    always #5 clk = ~clk;

    // predictor copy of the registers and window state
    logic [23:0] gain_q;
    logic [16:0] clip_q;
    logic [23:0] compress_q;
    logic [16:0] follow_q;
    logic signed [23:0] mix_q;
    longint unsigned energy_hist [bdvf_pkg::WINDOW_LEN];
    longint clipped_hist [bdvf_pkg::WINDOW_LEN];
    longint unsigned energy_total;
    longint unsigned clipped_total;
    int unsigned hist_pos;

    logic signed [23:0] expected_shaped [$];
    logic signed [23:0] expected_head;
    int error_count = 0;
    int cycle_count = 0;
    bit push_gaps = 1'b1;
    bit pop_stalls = 1'b1;

    typedef struct {
        bit is_cfg;
        logic [2:0] reg_idx;
        logic [31:0] value;
        logic signed [23:0] sample;
        bit typed;
        logic signed [23:0] want;
    } stim_row_t;

    task automatic report(string what, longint got, longint want);
        $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
        error_count++;
    endtask

    function automatic longint unsigned floor_root(longint unsigned v);
        longint unsigned r;
        longint unsigned b;
        r = 0;
        b = 64'd1 << 62;
        while (b > v)
            b >>= 2;
        while (b != 0)
        begin
            if (v >= r + b)
            begin
                v -= r + b;
                r = (r >> 1) + b;
            end
            else
                r >>= 1;
            b >>= 2;
        end
        return r;
    endfunction

    // magnitude product, shifted, sign put back; wraps at 64 bits
    function automatic longint trunc_mul(longint a, longint b, int sh);
        bit sgn;
        longint unsigned ma;
        longint unsigned mb;
        longint unsigned p;
        sgn = (a < 0) != (b < 0);
        ma = (a < 0) ? -a : a;
        mb = (b < 0) ? -b : b;
        p = (ma * mb) >> sh;
        return sgn ? -longint'(p) : longint'(p);
    endfunction

    function automatic void reset_predictor();
        gain_q = bdvf_pkg::RST_BAND_GAIN;
        clip_q = bdvf_pkg::RST_CLIP_LEVEL;
        compress_q = bdvf_pkg::RST_ENERGY_COMPRESS;
        follow_q = bdvf_pkg::RST_FOLLOW_AMOUNT;
        mix_q = bdvf_pkg::RST_MIX_WEIGHT;
        foreach (energy_hist[i])
        begin
            energy_hist[i] = 0;
            clipped_hist[i] = 0;
        end
        energy_total = 0;
        clipped_total = 0;
        hist_pos = 0;
    endfunction

    function automatic logic signed [23:0] shape_sample(logic signed [23:0] x);
        bit sgn;
        longint unsigned mag, x2, cx, den, e, m, sc, lim, rpre, rpost, term;
        longint y, old, scale, z, w;
        logic [127:0] wide;
        int unsigned nxt;
        sgn = x < 0;
        mag = sgn ? -longint'(x) : longint'(x);
        nxt = (hist_pos + 1 >= bdvf_pkg::WINDOW_LEN) ? 0 : hist_pos + 1;

        x2 = mag * mag;
        cx = (longint'(compress_q) * (x2 >> 20)
              + ((longint'(compress_q) * (x2 & 64'hFFFFF)) >> 20)) >> 16;
        den = Q20_ONE + cx;
        wide = {64'd0, x2} << 20;
        wide = wide / {64'd0, den};
        e = wide[63:0];
        energy_hist[hist_pos] = e;
        energy_total = (energy_total + e - energy_hist[nxt]) & SUM_MASK;
        rpre = floor_root(energy_total);

        m = (mag * longint'(gain_q)) >> 16;
        sc = (m << 20) / (Q20_ONE + m);
        lim = longint'(clip_q) << 4;
        if (sc > lim)
            sc = lim;
        y = sgn ? -longint'(sc) : longint'(sc);

        clipped_hist[hist_pos] = y;
        old = clipped_hist[nxt];
        clipped_total = (clipped_total + longint'(y * y) - longint'(old * old)) & SUM_MASK;
        rpost = floor_root(clipped_total);
        if (rpost < Q20_ONE)
            rpost = Q20_ONE;
        hist_pos = nxt;

        term = (longint'(follow_q) * rpre * 16) / rpost;
        scale = longint'(term) + longint'(Q20_ONE) - longint'(follow_q) * 16;
        z = trunc_mul(y, scale, 20);
        w = trunc_mul(z, longint'(mix_q), 16);
        if (w > 8388607)
            w = 8388607;
        if (w < -8388608)
            w = -8388608;
        return w[23:0];
    endfunction

    task automatic write_reg(logic [2:0] idx, logic [31:0] v);
        @(negedge clk);
        psel <= 1'b1;
        pwrite <= 1'b1;
        penable <= 1'b0;
        paddr <= {idx, 2'b00};
        pwdata <= v;
        @(negedge clk);
        penable <= 1'b1;
        @(negedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        case (idx)
            bdvf_pkg::REG_BAND_GAIN: gain_q = v[23:0];
            bdvf_pkg::REG_CLIP_LEVEL: clip_q = v[16:0];
            bdvf_pkg::REG_ENERGY_COMPRESS: compress_q = v[23:0];
            bdvf_pkg::REG_FOLLOW_AMOUNT: follow_q = v[16:0];
            bdvf_pkg::REG_MIX_WEIGHT: mix_q = v[23:0];
            default: ;
        endcase
    endtask

    // returns with the block idle so registers may be rewritten
    task automatic drain();
        @(negedge clk);
        push <= 1'b0;
        while (expected_shaped.size() != 0)
            @(posedge clk);
        repeat (DRAIN_WAIT) @(posedge clk);
    endtask

    task automatic send_request(logic signed [23:0] s, bit typed, logic signed [23:0] want);
        logic signed [23:0] pred;
        @(negedge clk);
        while (push_gaps && $urandom_range(99) < 17)
        begin
            push <= 1'b0;
            @(negedge clk);
        end
        push <= 1'b1;
        band_sample <= s;
        do
            @(posedge clk);
        while (full);
        pred = shape_sample(s);
        if (typed && pred !== want)
            report("predicted shaped_sample", pred, want);
        expected_shaped.insert(expected_shaped.size(), pred);
    endtask

    function automatic logic [31:0] pick_value(longint lo, longint hi);
        case ($urandom_range(4))
            0: return lo[31:0];
            1: return hi[31:0];
            2: return $urandom();
            default: return 32'(longint'($urandom_range(32'(hi - lo))) + lo);
        endcase
    endfunction

    function automatic logic signed [23:0] pick_sample();
        case ($urandom_range(9))
            0: return $urandom_range(1) ? 24'sh7FFFFF : 24'sh800000;
            1, 2, 3: return 24'($urandom_range(8191) - 4096);
            default: return 24'($urandom());
        endcase
    endfunction

    stim_row_t directed [] = '{
        '{0, REG_UNUSED, 0, 24'sd0, 1, 24'sd0},
        '{0, REG_UNUSED, 0, 24'sd1048576, 1, 24'sd524288},
        '{0, REG_UNUSED, 0, -24'sd1048576, 1, -24'sd524288},
        '{0, REG_UNUSED, 0, 24'sh7FFFFF, 0, 0},
        '{0, REG_UNUSED, 0, 24'sh800000, 0, 0},
        '{0, REG_UNUSED, 0, 24'sd1, 0, 0},
        '{0, REG_UNUSED, 0, -24'sd1, 0, 0},
        '{1, REG_UNUSED, 32'hFFFF_FFFF, 0, 0, 0},
        '{0, REG_UNUSED, 0, 24'sd1048576, 1, 24'sd524288},
        '{1, bdvf_pkg::REG_FOLLOW_AMOUNT, 32'd65536, 0, 0, 0},
        '{0, REG_UNUSED, 0, 24'sd4194304, 0, 0},
        '{0, REG_UNUSED, 0, -24'sd4194304, 0, 0},
        '{0, REG_UNUSED, 0, 24'sh7FFFFF, 0, 0},
        '{1, bdvf_pkg::REG_BAND_GAIN, 32'hFFFFFF, 0, 0, 0},
        '{1, bdvf_pkg::REG_CLIP_LEVEL, 32'd0, 0, 0, 0},
        '{0, REG_UNUSED, 0, 24'sh7FFFFF, 1, 24'sd0},
        '{0, REG_UNUSED, 0, -24'sd1, 1, 24'sd0},
        '{1, bdvf_pkg::REG_CLIP_LEVEL, 32'd65536, 0, 0, 0},
        '{1, bdvf_pkg::REG_ENERGY_COMPRESS, 32'hFFFFFF, 0, 0, 0},
        '{1, bdvf_pkg::REG_MIX_WEIGHT, 32'h800000, 0, 0, 0},
        '{0, REG_UNUSED, 0, 24'sh7FFFFF, 0, 0},
        '{0, REG_UNUSED, 0, 24'sh800000, 0, 0},
        '{0, REG_UNUSED, 0, 24'sd12345, 0, 0},
        '{1, bdvf_pkg::REG_FOLLOW_AMOUNT, 32'h1FFFF, 0, 0, 0},
        '{1, bdvf_pkg::REG_MIX_WEIGHT, 32'h7FFFFF, 0, 0, 0},
        '{0, REG_UNUSED, 0, 24'sd3000000, 0, 0},
        '{0, REG_UNUSED, 0, -24'sd77, 0, 0},
        '{0, REG_UNUSED, 0, 24'sh7FFFFF, 0, 0}
    };

    always @(negedge clk)
        pop <= pop_stalls ? ($urandom_range(99) >= 17) : 1'b1;

    always @(posedge clk)
    begin
        if (rst_n && pop && !empty)
        begin
            if (expected_shaped.size() == 0)
                report("unexpected shaped_sample", shaped_sample, 0);
            else
            begin
                expected_head = expected_shaped.pop_front();
                if (shaped_sample !== expected_head)
                    report("shaped_sample", shaped_sample, expected_head);
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("band_distortion_volume_follow verification failed");
            $finish;
        end
    end

    initial
    begin
        reset_predictor();
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        foreach (directed[i])
        begin
            if (directed[i].is_cfg)
            begin
                drain();
                write_reg(directed[i].reg_idx, directed[i].value);
            end
            else
                send_request(directed[i].sample, directed[i].typed, directed[i].want);
        end

        for (int ph = 0; ph < RANDOM_PHASES; ph++)
        begin
            drain();
            write_reg(bdvf_pkg::REG_BAND_GAIN, pick_value(0, 24'hFFFFFF));
            write_reg(bdvf_pkg::REG_CLIP_LEVEL, pick_value(0, 65536));
            write_reg(bdvf_pkg::REG_ENERGY_COMPRESS, pick_value(0, 24'hFFFFFF));
            write_reg(bdvf_pkg::REG_FOLLOW_AMOUNT, pick_value(0, 65536));
            write_reg(bdvf_pkg::REG_MIX_WEIGHT, pick_value(-8388608, 8388607));
            // one phase runs with both sides at full rate
            push_gaps = (ph != 3);
            pop_stalls = (ph != 3);
            for (int n = 0; n < PHASE_ITEMS; n++)
                send_request(pick_sample(), 1'b0, 24'sd0);
        end

        drain();
        if (error_count == 0)
            $display("band_distortion_volume_follow verification clean");
        else
            $display("band_distortion_volume_follow verification failed");
        $finish;
    end
endmodule
